// ----- hdl/ccg_pkg.sv -----
`default_nettype none
package ccg_pkg;

	localparam int POS_WIDTH_DEF    = 24;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam int CARROT_WIDTH     = 16;
	localparam int BEAR_WIDTH       = 16;
	localparam int TURN_WIDTH       = 32;
	localparam int VEC_WIDTH        = 40;
	localparam int ANG_WIDTH        = 30;

	localparam logic [CARROT_WIDTH-1:0] CARROT_RESET = 16'd1280;
	localparam longint MIN_RADIUS_LSB = 25;
	localparam longint A24_PI         = 52707179;
	localparam longint A24_HALF_PI    = 26353589;
	localparam longint A24_TWO_PI     = 105414357;
	localparam longint CARROT_MIN_A24 = 3294199;
	localparam longint CARROT_MAX_A24 = 13176795;
	localparam longint Q13_PI         = 25736;
	localparam longint Q13_TWO_PI     = 51472;
	localparam longint INV_GAIN_Q30   = 652032874;
	localparam longint NORM_LIMIT     = 64'sd1 << 29;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_ATAN,
		ST_TURN,
		ST_DIV,
		ST_ROT_PREP,
		ST_ROT,
		ST_MUL_X,
		ST_MUL_Y,
		ST_DONE
	} state_t;

	function automatic logic signed [ANG_WIDTH-1:0] atan_lut(input logic [4:0] idx);
		logic signed [ANG_WIDTH-1:0] v;
		begin
			case (idx)
				5'd0: v = 30'sd13176795;
				5'd1: v = 30'sd7778716;
				5'd2: v = 30'sd4110060;
				5'd3: v = 30'sd2086331;
				5'd4: v = 30'sd1047214;
				5'd5: v = 30'sd524117;
				5'd6: v = 30'sd262123;
				5'd7: v = 30'sd131069;
				default: v = (idx < 5'd24) ? (30'sd1 <<< (5'd24 - idx)) : 30'sd0;
			endcase
			return v;
		end
	endfunction

endpackage
`default_nettype wire

// ----- hdl/circle_carrot_guidance.sv -----
// Channel  Direction  Payload
// s_axis   in         tdata: pos_x, pos_y, center_x, center_y, radius
// m_axis   out        tdata: target_x, target_y, bearing, turned_total
// cfg      in         wr_data: look-ahead distance
// From the accepting beat to the result the block runs the normalizing shifts, the vectoring
// CORDIC, a 40-step restoring divider, the rotating CORDIC and the multiply states ST_MUL_X
// and ST_MUL_Y, all on the shared datapath.
// Radii of 0.1 m or less skip the divider and rotation.
// Reset clears the bearing history and the turned total and reloads a 5 m look-ahead.
// A result waits in the output register; a new beat is taken only after it leaves.
`default_nettype none
module circle_carrot_guidance #(
	parameter int POS_WIDTH    = ccg_pkg::POS_WIDTH_DEF,
	parameter int CORDIC_STEPS = ccg_pkg::CORDIC_STEPS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	// pos_x, pos_y, center_x, center_y, radius from the lowest bit up
	input  wire  [((5*POS_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	// target_x, target_y, bearing, turned_total from the lowest bit up
	output logic [((2*POS_WIDTH+48+7)/8)*8-1:0] m_axis_tdata,
	input  wire                          cfg_wr_en,
	input  wire  [15:0]                  cfg_wr_data
);
	import ccg_pkg::*;

	localparam int W = POS_WIDTH;
	localparam int OW = ((2*W+48+7)/8)*8;
	localparam int DIVW = CARROT_WIDTH + 24;

	state_t state_q, state_d;

	logic [15:0] carrot_q;
	logic signed [BEAR_WIDTH-1:0] last_q, bear13_q;
	logic signed [TURN_WIDTH-1:0] turn_q;
	logic signed [W-1:0] cx_q, cy_q, r_q;
	logic [W-1:0] absr_q;
	logic signed [VEC_WIDTH+8:0] x_q, y_q;
	logic signed [ANG_WIDTH:0] z_q, b24_q;
	logic [4:0] i_q;
	logic neg_q;
	logic [DIVW-1:0] quo_q;
	logic [W:0] rem_q;
	logic [6:0] dcnt_q;
	logic signed [W-1:0] tx_q;
	logic m_valid_q;
	logic [OW-1:0] m_data_q;

	logic signed [W-1:0] in_px, in_py, in_cx, in_cy, in_r;
	assign in_px = s_axis_tdata[0*W +: W];
	assign in_py = s_axis_tdata[1*W +: W];
	assign in_cx = s_axis_tdata[2*W +: W];
	assign in_cy = s_axis_tdata[3*W +: W];
	assign in_r  = s_axis_tdata[4*W +: W];

	logic step_last;
	assign step_last = (i_q == 5'(CORDIC_STEPS - 1)) || (i_q == 5'(ATAN_ENTRIES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_axis_tvalid && !m_valid_q) state_d = ST_NORM;
			ST_NORM: begin
				if (x_q == 0 && y_q == 0) state_d = ST_TURN;
				else if ((x_q < 0 ? -x_q : x_q) < NORM_LIMIT &&
					(y_q < 0 ? -y_q : y_q) < NORM_LIMIT) state_d = ST_NORM;
				else state_d = ST_ATAN;
			end
			ST_ATAN:     if (y_q == 0 || step_last) state_d = ST_TURN;
			ST_TURN:     state_d = (absr_q > W'(MIN_RADIUS_LSB)) ? ST_DIV : ST_DONE;
			ST_DIV:      if (dcnt_q == 7'(DIVW - 1)) state_d = ST_ROT_PREP;
			ST_ROT_PREP: state_d = ST_ROT;
			ST_ROT:      if (step_last) state_d = ST_MUL_X;
			ST_MUL_X:    state_d = ST_MUL_Y;
			ST_MUL_Y:    state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE) && !m_valid_q;
	end

	function automatic logic signed [VEC_WIDTH+8:0] sra(input logic signed [VEC_WIDTH+8:0] v,
		input logic [4:0] s);
		return v >>> s;
	endfunction

	function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
		logic signed [W+1:0] hi, lo;
		begin
			hi = (W+2)'((64'sd1 <<< (W-1)) - 1);
			lo = -hi - 1;
			return (v > hi) ? W'(hi) : ((v < lo) ? W'(lo) : W'(v));
		end
	endfunction

	logic signed [17:0] diff;
	logic signed [33:0] sum;
	logic signed [ANG_WIDTH:0] zc;
	logic signed [ANG_WIDTH:0] b13w;
	logic [W:0] rem_sh;
	logic signed [ANG_WIDTH+1:0] th0;
	logic signed [W+33:0] prod;
	logic signed [W+1:0] tpos;
	logic signed [VEC_WIDTH+8:0] rot_x;

	always_comb begin
		if (z_q > 31'(A24_PI)) zc = 31'(A24_PI);
		else if (z_q < -31'(A24_PI)) zc = -31'(A24_PI);
		else zc = z_q;
		b13w = (zc + 31'sd1024) >>> 11;
		diff = 18'(b13w) - 18'(last_q);
		if (diff > 18'(Q13_PI)) diff = diff - 18'(Q13_TWO_PI);
		else if (diff < -18'(Q13_PI)) diff = diff + 18'(Q13_TWO_PI);
		sum = 34'(turn_q) + 34'(diff);
		rem_sh = {rem_q[W-1:0], quo_q[DIVW-1]};
		th0 = 32'(b24_q);
		prod = (W+34)'($signed({1'b0, absr_q})) * (W+34)'($signed(x_q[31:0])) +
			((W+34)'(1) <<< 29);
		tpos = (W+2)'(cx_q) + (W+2)'(prod >>> 30);
		rot_x = (z_q >= 0) ? x_q - sra(y_q, i_q) : x_q + sra(y_q, i_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			carrot_q  <= CARROT_RESET;
			last_q    <= '0;
			turn_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) carrot_q <= cfg_wr_data;
			if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
			if (state_q == ST_TURN) begin
				last_q <= 16'(b13w);
				if (sum > 34'sd2147483647) turn_q <= 32'h7fffffff;
				else if (sum < -34'sd2147483648) turn_q <= 32'h80000000;
				else turn_q <= 32'(sum);
			end
			if (state_q == ST_DONE) m_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cx_q <= in_cx;
				cy_q <= in_cy;
				r_q <= in_r;
				absr_q <= W'(in_r < 0 ? -(W+1)'(in_r) : (W+1)'(in_r));
				x_q <= (VEC_WIDTH+9)'(in_px) - (VEC_WIDTH+9)'(in_cx);
				y_q <= (VEC_WIDTH+9)'(in_py) - (VEC_WIDTH+9)'(in_cy);
				z_q <= '0;
				i_q <= '0;
			end
			ST_NORM: begin
				if (!(x_q == 0 && y_q == 0)) begin
					if ((x_q < 0 ? -x_q : x_q) < NORM_LIMIT &&
						(y_q < 0 ? -y_q : y_q) < NORM_LIMIT) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else if (x_q < 0) begin
						z_q <= (y_q >= 0) ? 31'(A24_PI) : -31'(A24_PI);
						x_q <= -x_q;
						y_q <= -y_q;
					end
				end
			end
			ST_ATAN: begin
				if (y_q != 0) begin
					if (y_q > 0) begin
						x_q <= x_q + sra(y_q, i_q);
						y_q <= y_q - sra(x_q, i_q);
						z_q <= z_q + 31'(atan_lut(i_q));
					end else begin
						x_q <= x_q - sra(y_q, i_q);
						y_q <= y_q + sra(x_q, i_q);
						z_q <= z_q - 31'(atan_lut(i_q));
					end
					i_q <= i_q + 5'd1;
				end
			end
			ST_TURN: begin
				b24_q <= zc;
				bear13_q <= 16'(b13w);
				quo_q <= DIVW'(carrot_q) << 24;
				rem_q <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				if (rem_sh >= (W+1)'(absr_q)) begin
					rem_q <= rem_sh - (W+1)'(absr_q);
					quo_q <= {quo_q[DIVW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DIVW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 7'd1;
			end
			ST_ROT_PREP: begin
				logic signed [ANG_WIDTH+1:0] ca, th;
				logic nflag;
				ca = (quo_q > DIVW'(CARROT_MAX_A24)) ? 32'(CARROT_MAX_A24) :
					((quo_q < DIVW'(CARROT_MIN_A24)) ? 32'(CARROT_MIN_A24) : 32'(quo_q));
				th = (r_q > 0) ? th0 - ca : th0 + ca;
				if (th > 32'(A24_PI)) th = th - 32'(A24_TWO_PI);
				if (th < -32'(A24_PI)) th = th + 32'(A24_TWO_PI);
				nflag = 1'b0;
				if (th > 32'(A24_HALF_PI)) begin
					th = th - 32'(A24_PI);
					nflag = 1'b1;
				end else if (th < -32'(A24_HALF_PI)) begin
					th = th + 32'(A24_PI);
					nflag = 1'b1;
				end
				neg_q <= nflag;
				z_q <= 31'(th);
				x_q <= (VEC_WIDTH+9)'(INV_GAIN_Q30);
				y_q <= '0;
				i_q <= '0;
			end
			ST_ROT: begin
				x_q <= (step_last && neg_q) ? -rot_x : rot_x;
				if (z_q >= 0) begin
					y_q <= y_q + sra(x_q, i_q);
					z_q <= z_q - 31'(atan_lut(i_q));
				end else begin
					y_q <= y_q - sra(x_q, i_q);
					z_q <= z_q + 31'(atan_lut(i_q));
				end
				i_q <= i_q + 5'd1;
			end
			ST_MUL_X: begin
				tx_q <= sat(tpos);
				x_q <= neg_q ? -y_q : y_q;
				cx_q <= cy_q;
			end
			ST_MUL_Y: begin
				cy_q <= sat(tpos);
				cx_q <= tx_q;
			end
			ST_DONE: begin
				m_data_q <= OW'({turn_q, bear13_q, cy_q, cx_q});
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
	ast_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
	ast_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> m_axis_tvalid) else $error("result not raised");
`endif

endmodule
`default_nettype wire

// ----- dv/circle_carrot_guidance_tb.sv -----
`timescale 1ns / 100ps
module circle_carrot_guidance_tb;
	import ccg_pkg::*;

	localparam int PW = 24;

	typedef struct {
		bit is_cfg;
		logic [15:0] cfg_val;
		logic [PW-1:0] px, py, cx, cy, rad;
	} pend_t;

	typedef struct {
		logic [PW-1:0] tx, ty;
		logic [15:0] bear;
		logic [31:0] turned;
	} target_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	wire s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	wire m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	wire [95:0] m_axis_tdata;
	logic cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	circle_carrot_guidance u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	pend_t pending[$];
	target_t targets_due[$];
	int errors = 0;
	int taken_cnt = 0;
	int seen_cnt = 0;
	int idle_cycles = 0;
	int src_gap = 0;
	int sink_gap = 0;
	bit running = 0;

	logic [15:0] carrot_q = CARROT_RESET;
	logic signed [15:0] last_bear_q = '0;
	logic signed [31:0] turned_q = '0;

	longint atan_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
		262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	function automatic longint bearing_a24(longint x, longint y);
		longint z, ax, ay, big, nx, ny;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		big = ax > ay ? ax : ay;
		while (big < (64'sd1 << 29)) begin
			x = x * 2; y = y * 2; big = big * 2;
		end
		if (x < 0) begin
			z = (y >= 0) ? A24_PI : -A24_PI;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			if (y == 0)
				break;
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
			end
			x = nx; y = ny;
		end
		if (z > A24_PI) z = A24_PI;
		if (z < -A24_PI) z = -A24_PI;
		return z;
	endfunction

	function automatic void rotate_unit(input longint th, output longint c, output longint s);
		longint x, y, nx, ny;
		bit neg;
		x = INV_GAIN_Q30;
		y = 0;
		neg = 0;
		if (th > A24_PI) th -= A24_TWO_PI;
		if (th < -A24_PI) th += A24_TWO_PI;
		if (th > A24_HALF_PI) begin
			th -= A24_PI; neg = 1;
		end else if (th < -A24_HALF_PI) begin
			th += A24_PI; neg = 1;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			if (th >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); th -= atan_tab[i];
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); th += atan_tab[i];
			end
			x = nx; y = ny;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic longint clamp_pos(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	task automatic predict_target(input logic [119:0] d);
		longint px, py, cx, cy, r, ar, b24, b13, diff, sum, tx, ty, q, th, c, s;
		target_t t;
		px = longint'($signed(d[23:0]));
		py = longint'($signed(d[47:24]));
		cx = longint'($signed(d[71:48]));
		cy = longint'($signed(d[95:72]));
		r = longint'($signed(d[119:96]));
		ar = r < 0 ? -r : r;
		b24 = bearing_a24(px - cx, py - cy);
		b13 = (b24 + 1024) >>> 11;
		diff = b13 - longint'(last_bear_q);
		if (diff > Q13_PI) diff -= Q13_TWO_PI;
		else if (diff < -Q13_PI) diff += Q13_TWO_PI;
		sum = longint'(turned_q) + diff;
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		turned_q = sum[31:0];
		last_bear_q = b13[15:0];
		tx = cx;
		ty = cy;
		if (ar > MIN_RADIUS_LSB) begin
			q = (longint'(carrot_q) << 24) / ar;
			if (q > CARROT_MAX_A24) q = CARROT_MAX_A24;
			if (q < CARROT_MIN_A24) q = CARROT_MIN_A24;
			th = (r > 0) ? (b24 - q) : (b24 + q);
			rotate_unit(th, c, s);
			tx = cx + ((ar * c + (64'sd1 << 29)) >>> 30);
			ty = cy + ((ar * s + (64'sd1 << 29)) >>> 30);
		end
		tx = clamp_pos(tx);
		ty = clamp_pos(ty);
		t.tx = tx[23:0];
		t.ty = ty[23:0];
		t.bear = b13[15:0];
		t.turned = turned_q;
		targets_due.push_back(t);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		target_t t;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_target(s_axis_tdata);
				taken_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (targets_due.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					t = targets_due.pop_front();
					if (m_axis_tdata[23:0] !== t.tx)
						report_mismatch("target_x", $signed(m_axis_tdata[23:0]), $signed(t.tx));
					if (m_axis_tdata[47:24] !== t.ty)
						report_mismatch("target_y", $signed(m_axis_tdata[47:24]), $signed(t.ty));
					if (m_axis_tdata[63:48] !== t.bear)
						report_mismatch("bearing", $signed(m_axis_tdata[63:48]), $signed(t.bear));
					if (m_axis_tdata[95:64] !== t.turned)
						report_mismatch("turned_total", $signed(m_axis_tdata[95:64]),
							$signed(t.turned));
				end
			end
			if (targets_due.size() == 0 && !s_axis_tvalid)
				idle_cycles++;
			else
				idle_cycles = 0;
		end
	end

	always @(negedge clk) begin
		logic nv, nwe, late;
		pend_t p;
		nv = s_axis_tvalid;
		nwe = 1'b0;
		late = pending.size() < 150;
		if (running) begin
			if (s_axis_tvalid && taken_cnt != seen_cnt) begin
				seen_cnt = taken_cnt;
				nv = 1'b0;
			end
			if (!nv) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending.size() > 0) begin
					if (pending[0].is_cfg) begin
						if (idle_cycles >= 200) begin
							p = pending.pop_front();
							nwe = 1'b1;
							cfg_wr_data <= p.cfg_val;
							carrot_q = p.cfg_val;
						end
					end else begin
						p = pending.pop_front();
						nv = 1'b1;
						s_axis_tdata <= {p.rad, p.cy, p.cx, p.py, p.px};
						if (!late && $urandom_range(0, 2) == 0)
							src_gap = $urandom_range(1, 17);
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!late && $urandom_range(0, 3) == 0)
					sink_gap = $urandom_range(1, 17);
			end
		end
		s_axis_tvalid <= nv;
		cfg_wr_en <= nwe;
	end

	task automatic add_item(input longint px, py, cx, cy, r);
		pend_t p;
		p.is_cfg = 0;
		p.cfg_val = '0;
		p.px = px[23:0];
		p.py = py[23:0];
		p.cx = cx[23:0];
		p.cy = cy[23:0];
		p.rad = r[23:0];
		pending.push_back(p);
	endtask

	task automatic add_cfg(input logic [15:0] v);
		pend_t p;
		p.is_cfg = 1;
		p.cfg_val = v;
		p.px = '0; p.py = '0; p.cx = '0; p.cy = '0; p.rad = '0;
		pending.push_back(p);
	endtask

	task automatic add_orbit(input int count);
		longint cx, cy, r, ar, px, py;
		real ang, rr;
		cx = longint'($urandom_range(0, 2097152)) - 1048576;
		cy = longint'($urandom_range(0, 2097152)) - 1048576;
		ar = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(26, 60000);
		r = $urandom_range(0, 1) ? ar : -ar;
		ang = $urandom_range(0, 6283) / 1000.0;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				ang = ang + ($urandom_range(0, 6283) / 1000.0);
			else
				ang = ang + (real'($urandom_range(0, 600)) - 300.0) / 1000.0;
			rr = real'(ar) + real'($urandom_range(0, 200)) - 100.0;
			px = cx + $rtoi(rr * $cos(ang));
			py = cy + $rtoi(rr * $sin(ang));
			add_item(px, py, cx, cy, r);
		end
	endtask

	initial begin
		logic [15:0] cfgs[5];
		cfgs = '{16'd0, 16'd65535, 16'd1280, 16'd1, 16'd0};
		add_item(0, 0, 0, 0, 1000);
		add_item(500, 0, 0, 0, 500);
		add_item(0, 500, 0, 0, -500);
		add_item(-500, 0, 0, 0, 500);
		add_item(0, -500, 0, 0, 500);
		add_item(-500, 1, 0, 0, 500);
		add_item(-500, -1, 0, 0, 500);
		add_item(300, 300, 0, 0, 0);
		add_item(300, 300, 0, 0, 25);
		add_item(300, 300, 0, 0, -25);
		add_item(300, 300, 0, 0, 26);
		add_item(8388607, 8388607, -8388608, -8388608, 8388607);
		add_item(-8388608, -8388608, 8388607, 8388607, -8388608);
		add_item(8388607, 0, 8388000, 8388000, 8388607);
		add_item(-8388608, 8388607, 0, 0, -8388607);
		add_cfg(16'd0);
		add_item(100, 100, 0, 0, 4000);
		add_item(100, -100, 0, 0, -4000);
		add_cfg(16'd65535);
		add_item(100, 100, 0, 0, 26);
		add_item(-100, 100, 0, 0, 8388607);
		add_cfg(16'd1280);
		for (int ph = 0; ph < 5; ph++) begin
			for (int k = 0; k < 8; k++)
				add_orbit($urandom_range(20, 50));
			for (int k = 0; k < 40; k++)
				add_item(longint'($urandom), longint'($urandom), longint'($urandom),
					longint'($urandom), longint'($urandom));
			if (ph < 4)
				add_cfg(ph == 3 ? 16'($urandom) : cfgs[ph]);
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		running = 1;
		while (pending.size() > 0 || s_axis_tvalid || targets_due.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
